// File: design/cmu_pkg.sv
package cmu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int TRIG_ITER_DEF = 16;

	// angle and cordic datapath width, q30 with headroom
	localparam int ANG_W = 34;

	localparam logic signed [63:0] Q30_PI      = 64'sd3373259426;
	localparam logic signed [63:0] Q30_HALF_PI = 64'sd1686629713;
	localparam logic signed [63:0] Q30_TWO_PI  = 64'sd6746518852;
	localparam logic signed [ANG_W-1:0] Q30_GAIN = 34'sd652032874;

	// straight path when |turn_rate| * 10000 < 1.0
	localparam int TURN_BOUND_INV = 10000;

	// truncated q30 atan(2^-i)
	function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
		logic signed [ANG_W-1:0] v;
		unique case (idx)
			0: v = 34'sd843314856;
			1: v = 34'sd497837829;
			2: v = 34'sd263043836;
			3: v = 34'sd133525158;
			4: v = 34'sd66987886;
			5: v = 34'sd33543515;
			6: v = 34'sd16775850;
			7: v = 34'sd8388437;
			8: v = 34'sd4194282;
			9: v = 34'sd2097149;
			10: v = 34'sd1048575;
			11: v = 34'sd524287;
			12: v = 34'sd262143;
			13: v = 34'sd131071;
			14: v = 34'sd65535;
			15: v = 34'sd32767;
			16: v = 34'sd16383;
			17: v = 34'sd8191;
			18: v = 34'sd4095;
			19: v = 34'sd2047;
			20: v = 34'sd1023;
			21: v = 34'sd511;
			22: v = 34'sd255;
			23: v = 34'sd127;
			24: v = 34'sd63;
			25: v = 34'sd31;
			26: v = 34'sd15;
			27: v = 34'sd8;
			28: v = 34'sd4;
			29: v = 34'sd2;
			30: v = 34'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: design/cmu_rot_cell.sv
module cmu_rot_cell #(
	parameter int IDX = 0,
	parameter logic signed [cmu_pkg::ANG_W-1:0] ATAN = '0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic vld_i,
	input  logic signed [cmu_pkg::ANG_W-1:0] x_i,
	input  logic signed [cmu_pkg::ANG_W-1:0] y_i,
	input  logic signed [cmu_pkg::ANG_W-1:0] z_i,
	input  logic flip_i,
	output logic vld_o,
	output logic signed [cmu_pkg::ANG_W-1:0] x_o,
	output logic signed [cmu_pkg::ANG_W-1:0] y_o,
	output logic signed [cmu_pkg::ANG_W-1:0] z_o,
	output logic flip_o
);

	logic signed [cmu_pkg::ANG_W-1:0] xs, ys;
	logic vld_q, flip_q;
	logic signed [cmu_pkg::ANG_W-1:0] x_q, y_q, z_q;

	assign xs = x_i >>> IDX;
	assign ys = y_i >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		flip_q <= flip_i;
		if (!z_i[cmu_pkg::ANG_W-1]) begin
			x_q <= x_i - ys;
			y_q <= y_i + xs;
			z_q <= z_i - ATAN;
		end else begin
			x_q <= x_i + ys;
			y_q <= y_i - xs;
			z_q <= z_i + ATAN;
		end
	end

	assign vld_o  = vld_q;
	assign x_o    = x_q;
	assign y_o    = y_q;
	assign z_o    = z_q;
	assign flip_o = flip_q;

endmodule

// File: design/cmu_trig.sv
module cmu_trig #(
	parameter int FRAC_BITS = cmu_pkg::FRAC_BITS_DEF,
	parameter int TRIG_ITERATIONS = cmu_pkg::TRIG_ITER_DEF,
	parameter int SIDE_W = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic vld_i,
	input  logic signed [31:0] ang_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic vld_o,
	output logic signed [FRAC_BITS+1:0] sin_o,
	output logic signed [FRAC_BITS+1:0] cos_o,
	output logic [SIDE_W-1:0] side_o
);

	localparam int AW = cmu_pkg::ANG_W;
	localparam int SH = 30 - FRAC_BITS;
	localparam int RN = 30 - FRAC_BITS;
	localparam int OUT_W = FRAC_BITS + 2;
	localparam int LAT = RN + TRIG_ITERATIONS + 3;
	// pi plus a multiple of 2pi that makes every input angle non-negative
	localparam logic signed [63:0] OFS =
		cmu_pkg::Q30_PI + (cmu_pkg::Q30_TWO_PI <<< (29 - FRAC_BITS));
	localparam logic signed [AW-1:0] ONE = AW'(1) <<< FRAC_BITS;

	logic red_vld_q [RN+1];
	logic signed [63:0] red_q [RN+1];

	// range reduction: remove 2pi*2^j for j from high to low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_vld_q[0] <= 1'b0;
		end else begin
			red_vld_q[0] <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		red_q[0] <= (64'(ang_i) <<< SH) + OFS;
	end

	for (genvar j = 0; j < RN; j++) begin : g_red
		localparam logic signed [63:0] STEP = cmu_pkg::Q30_TWO_PI <<< (RN - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				red_vld_q[j+1] <= 1'b0;
			end else begin
				red_vld_q[j+1] <= red_vld_q[j];
			end
		end

		always_ff @(posedge clk) begin
			red_q[j+1] <= (red_q[j] >= STEP) ? red_q[j] - STEP : red_q[j];
		end
	end

	// fold into [-pi/2, pi/2]
	logic signed [63:0] zr;
	logic signed [AW-1:0] zf;
	logic ff;
	logic fold_vld_q, fold_flip_q;
	logic signed [AW-1:0] fold_z_q;

	always_comb begin
		zr = red_q[RN] - cmu_pkg::Q30_PI;
		ff = 1'b0;
		zf = AW'(zr);
		priority if (zr > cmu_pkg::Q30_HALF_PI) begin
			zf = AW'(zr - cmu_pkg::Q30_PI);
			ff = 1'b1;
		end else if (zr < -cmu_pkg::Q30_HALF_PI) begin
			zf = AW'(zr + cmu_pkg::Q30_PI);
			ff = 1'b1;
		end else begin
			zf = AW'(zr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_vld_q <= 1'b0;
		end else begin
			fold_vld_q <= red_vld_q[RN];
		end
	end

	always_ff @(posedge clk) begin
		fold_z_q    <= zf;
		fold_flip_q <= ff;
	end

	logic rot_vld [TRIG_ITERATIONS+1];
	logic rot_flip [TRIG_ITERATIONS+1];
	logic signed [AW-1:0] rot_x [TRIG_ITERATIONS+1];
	logic signed [AW-1:0] rot_y [TRIG_ITERATIONS+1];
	logic signed [AW-1:0] rot_z [TRIG_ITERATIONS+1];

	assign rot_vld[0]  = fold_vld_q;
	assign rot_flip[0] = fold_flip_q;
	assign rot_x[0]    = cmu_pkg::Q30_GAIN;
	assign rot_y[0]    = '0;
	assign rot_z[0]    = fold_z_q;

	for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_rot
		cmu_rot_cell #(
			.IDX(i),
			.ATAN(cmu_pkg::atan_q30(i))
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.vld_i (rot_vld[i]),
			.x_i   (rot_x[i]),
			.y_i   (rot_y[i]),
			.z_i   (rot_z[i]),
			.flip_i(rot_flip[i]),
			.vld_o (rot_vld[i+1]),
			.x_o   (rot_x[i+1]),
			.y_o   (rot_y[i+1]),
			.z_o   (rot_z[i+1]),
			.flip_o(rot_flip[i+1])
		);
	end

	// undo the fold, scale to output format, clamp to [-1, 1]
	logic signed [AW-1:0] xf, yf, xs, ys, xc, yc;
	logic out_vld_q;
	logic signed [OUT_W-1:0] sin_q, cos_q;

	always_comb begin
		xf = rot_flip[TRIG_ITERATIONS] ? -rot_x[TRIG_ITERATIONS] : rot_x[TRIG_ITERATIONS];
		yf = rot_flip[TRIG_ITERATIONS] ? -rot_y[TRIG_ITERATIONS] : rot_y[TRIG_ITERATIONS];
		xs = xf >>> SH;
		ys = yf >>> SH;
		xc = (xs > ONE) ? ONE : ((xs < -ONE) ? -ONE : xs);
		yc = (ys > ONE) ? ONE : ((ys < -ONE) ? -ONE : ys);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= rot_vld[TRIG_ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		cos_q <= OUT_W'(xc);
		sin_q <= OUT_W'(yc);
	end

	// side data rides along for the full latency
	logic [SIDE_W-1:0] side_q [LAT+1];

	assign side_q[0] = side_i;

	for (genvar k = 0; k < LAT; k++) begin : g_side
		always_ff @(posedge clk) begin
			side_q[k+1] <= side_q[k];
		end
	end

	assign vld_o  = out_vld_q;
	assign sin_o  = sin_q;
	assign cos_o  = cos_q;
	assign side_o = side_q[LAT];

endmodule

// File: design/cmu_div_cell.sv
module cmu_div_cell #(
	parameter int MW = 50
) (
	input  logic clk,
	input  logic arst_n,
	input  logic vld_i,
	input  logic [31:0] rem_i,
	input  logic [MW-1:0] num_i,
	input  logic [MW-1:0] quo_i,
	input  logic [31:0] den_i,
	input  logic neg_i,
	output logic vld_o,
	output logic [31:0] rem_o,
	output logic [MW-1:0] num_o,
	output logic [MW-1:0] quo_o,
	output logic [31:0] den_o,
	output logic neg_o
);

	logic [32:0] t, diff;
	logic ge;
	logic vld_q, neg_q;
	logic [31:0] rem_q, den_q;
	logic [MW-1:0] num_q, quo_q;

	// restoring step: one quotient bit
	always_comb begin
		t    = {rem_i, num_i[MW-1]};
		ge   = t >= {1'b0, den_i};
		diff = t - {1'b0, den_i};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= ge ? diff[31:0] : t[31:0];
		num_q <= num_i << 1;
		quo_q <= {quo_i[MW-2:0], ge};
		den_q <= den_i;
		neg_q <= neg_i;
	end

	assign vld_o = vld_q;
	assign rem_o = rem_q;
	assign num_o = num_q;
	assign quo_o = quo_q;
	assign den_o = den_q;
	assign neg_o = neg_q;

endmodule

// File: design/cmu_div.sv
module cmu_div #(
	parameter int NW = 51,
	parameter int SIDE_W = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic vld_i,
	input  logic signed [NW-1:0] num_i,
	input  logic signed [31:0] den_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic vld_o,
	output logic signed [NW-1:0] quo_o,
	output logic [SIDE_W-1:0] side_o
);

	localparam int MW = NW - 1;
	localparam int LAT = MW + 2;

	logic c_vld [MW+1];
	logic c_neg [MW+1];
	logic [31:0] c_rem [MW+1];
	logic [31:0] c_den [MW+1];
	logic [MW-1:0] c_num [MW+1];
	logic [MW-1:0] c_quo [MW+1];

	logic signed [NW-1:0] nabs;
	logic signed [31:0] dabs;
	logic ent_vld_q, ent_neg_q;
	logic [MW-1:0] ent_num_q;
	logic [31:0] ent_den_q;

	// magnitudes and quotient sign, truncation toward zero
	assign nabs = num_i[NW-1] ? -num_i : num_i;
	assign dabs = den_i[31] ? -den_i : den_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= 1'b0;
		end else begin
			ent_vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		ent_neg_q <= num_i[NW-1] ^ den_i[31];
		ent_num_q <= nabs[MW-1:0];
		ent_den_q <= dabs;
	end

	assign c_vld[0] = ent_vld_q;
	assign c_neg[0] = ent_neg_q;
	assign c_rem[0] = '0;
	assign c_den[0] = ent_den_q;
	assign c_num[0] = ent_num_q;
	assign c_quo[0] = '0;

	for (genvar i = 0; i < MW; i++) begin : g_cell
		cmu_div_cell #(.MW(MW)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.vld_i (c_vld[i]),
			.rem_i (c_rem[i]),
			.num_i (c_num[i]),
			.quo_i (c_quo[i]),
			.den_i (c_den[i]),
			.neg_i (c_neg[i]),
			.vld_o (c_vld[i+1]),
			.rem_o (c_rem[i+1]),
			.num_o (c_num[i+1]),
			.quo_o (c_quo[i+1]),
			.den_o (c_den[i+1]),
			.neg_o (c_neg[i+1])
		);
	end

	logic out_vld_q;
	logic signed [NW-1:0] quo_q, qpos;

	assign qpos = $signed({1'b0, c_quo[MW]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= c_vld[MW];
		end
	end

	always_ff @(posedge clk) begin
		quo_q <= c_neg[MW] ? -qpos : qpos;
	end

	logic [SIDE_W-1:0] side_q [LAT+1];

	assign side_q[0] = side_i;

	for (genvar k = 0; k < LAT; k++) begin : g_side
		always_ff @(posedge clk) begin
			side_q[k+1] <= side_q[k];
		end
	end

	assign vld_o  = out_vld_q;
	assign quo_o  = quo_q;
	assign side_o = side_q[LAT];

endmodule

// File: design/ctrv_particle_motion_update.sv
// throughput: one particle per cycle, busy is never raised
// latency is set by the angle reduction and cordic cell rows plus one divider cell
// per quotient bit of the arc path
// done pulses for one cycle with the result; the receiver cannot stall
// reset clears all valid bits at once, no clearing pass
module ctrv_particle_motion_update #(
	parameter int FRAC_BITS = cmu_pkg::FRAC_BITS_DEF,
	parameter int TRIG_ITERATIONS = cmu_pkg::TRIG_ITER_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [31:0] pose_x,
	input  logic signed [31:0] pose_y,
	input  logic signed [31:0] heading,
	input  logic signed [31:0] speed,
	input  logic signed [31:0] turn_rate,
	input  logic [30:0] time_step,
	input  logic signed [31:0] noise_x,
	input  logic signed [31:0] noise_y,
	input  logic signed [31:0] noise_heading,
	output logic done,
	output logic signed [31:0] new_x,
	output logic signed [31:0] new_y,
	output logic signed [31:0] new_heading
);

	localparam int OUT_W = FRAC_BITS + 2;
	localparam int BW = FRAC_BITS + 3;
	localparam int DW = 64 - FRAC_BITS;
	localparam int PW = DW + BW;
	localparam int NW = 32 + BW;
	localparam int T0_SW = 6 * 32;
	localparam int T1_SW = 1 + DW + 64;
	localparam int DX_SW = 1 + 4 * 32 + 64;
	localparam int DY_SW = 2 * 32 + 64;
	localparam int LAT = 4 + (33 - FRAC_BITS + TRIG_ITERATIONS) + (NW + 1);

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	logic acc;
	assign busy = 1'b0;
	assign acc  = start && !busy;

	// stage 1: products with time step, straight-path test
	logic [31:0] aw;
	logic signed [63:0] wdt, vdt;
	logic straight;

	assign aw  = turn_rate[31] ? 32'(-turn_rate) : 32'(turn_rate);
	assign wdt = turn_rate * $signed({1'b0, time_step});
	assign vdt = speed * $signed({1'b0, time_step});
	assign straight = (46'(aw) * 46'(cmu_pkg::TURN_BOUND_INV)) < (46'(1) << FRAC_BITS);

	logic vld_s1, straight_s1;
	logic signed [63:0] wdt_s1, vdt_s1;
	logic signed [31:0] h_s1, v_s1, w_s1, px_s1, py_s1, nx_s1, ny_s1, nh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		straight_s1 <= straight;
		wdt_s1 <= wdt;
		vdt_s1 <= vdt;
		h_s1   <= heading;
		v_s1   <= speed;
		w_s1   <= turn_rate;
		px_s1  <= pose_x;
		py_s1  <= pose_y;
		nx_s1  <= noise_x;
		ny_s1  <= noise_y;
		nh_s1  <= noise_heading;
	end

	// stage 2: end heading and travelled distance
	logic signed [31:0] phi;
	assign phi = sat32(64'(h_s1) + (wdt_s1 >>> FRAC_BITS));

	logic vld_s2, straight_s2;
	logic signed [DW-1:0] d_s2;
	logic signed [31:0] h_s2, phi_s2, hn_s2, v_s2, w_s2, px_s2, py_s2, nx_s2, ny_s2, nh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		straight_s2 <= straight_s1;
		d_s2   <= DW'(vdt_s1 >>> FRAC_BITS);
		h_s2   <= h_s1;
		phi_s2 <= phi;
		hn_s2  <= straight_s1 ? h_s1 : phi;
		v_s2   <= v_s1;
		w_s2   <= w_s1;
		px_s2  <= px_s1;
		py_s2  <= py_s1;
		nx_s2  <= nx_s1;
		ny_s2  <= ny_s1;
		nh_s2  <= nh_s1;
	end

	// both trig units run side by side
	logic t0_vld, t1_vld;
	logic signed [OUT_W-1:0] sn0, cs0, sn1, cs1;
	logic [T0_SW-1:0] t0_side;
	logic [T1_SW-1:0] t1_side;

	cmu_trig #(
		.FRAC_BITS(FRAC_BITS),
		.TRIG_ITERATIONS(TRIG_ITERATIONS),
		.SIDE_W(T0_SW)
	) u_trig_h (
		.clk   (clk),
		.arst_n(arst_n),
		.vld_i (vld_s2),
		.ang_i (h_s2),
		.side_i({px_s2, py_s2, nx_s2, ny_s2, nh_s2, hn_s2}),
		.vld_o (t0_vld),
		.sin_o (sn0),
		.cos_o (cs0),
		.side_o(t0_side)
	);

	cmu_trig #(
		.FRAC_BITS(FRAC_BITS),
		.TRIG_ITERATIONS(TRIG_ITERATIONS),
		.SIDE_W(T1_SW)
	) u_trig_phi (
		.clk   (clk),
		.arst_n(arst_n),
		.vld_i (vld_s2),
		.ang_i (phi_s2),
		.side_i({straight_s2, d_s2, v_s2, w_s2}),
		.vld_o (t1_vld),
		.sin_o (sn1),
		.cos_o (cs1),
		.side_o(t1_side)
	);

	logic signed [31:0] t_px, t_py, t_nx, t_ny, t_nh, t_hn, t_v, t_w;
	logic signed [DW-1:0] t_d;
	logic t_straight;

	assign {t_px, t_py, t_nx, t_ny, t_nh, t_hn} = t0_side;
	assign {t_straight, t_d, t_v, t_w} = t1_side;

	// stage 3: one shared multiplier per axis, operands picked by path
	logic signed [DW-1:0] op_a;
	logic signed [BW-1:0] op_bx, op_by;

	always_comb begin
		op_a  = t_straight ? t_d : DW'(t_v);
		op_bx = t_straight ? BW'(cs0) : BW'(sn1) - BW'(sn0);
		op_by = t_straight ? BW'(sn0) : BW'(cs0) - BW'(cs1);
	end

	logic vld_s3, straight_s3;
	logic signed [PW-1:0] prod_x_s3, prod_y_s3;
	logic signed [31:0] w_s3, px_s3, py_s3, nx_s3, ny_s3, nh_s3, hn_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= t0_vld && t1_vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_x_s3   <= op_a * op_bx;
		prod_y_s3   <= op_a * op_by;
		straight_s3 <= t_straight;
		w_s3  <= t_w;
		px_s3 <= t_px;
		py_s3 <= t_py;
		nx_s3 <= t_nx;
		ny_s3 <= t_ny;
		nh_s3 <= t_nh;
		hn_s3 <= t_hn;
	end

	// arc path divides by turn rate; straight result travels as side data
	logic signed [63:0] stx, sty;
	assign stx = 64'(prod_x_s3 >>> FRAC_BITS);
	assign sty = 64'(prod_y_s3 >>> FRAC_BITS);

	logic dx_vld, dy_vld;
	logic signed [NW-1:0] qx, qy;
	logic [DX_SW-1:0] dx_side;
	logic [DY_SW-1:0] dy_side;

	cmu_div #(.NW(NW), .SIDE_W(DX_SW)) u_div_x (
		.clk   (clk),
		.arst_n(arst_n),
		.vld_i (vld_s3),
		.num_i (NW'(prod_x_s3)),
		.den_i (w_s3),
		.side_i({straight_s3, px_s3, nx_s3, hn_s3, nh_s3, stx}),
		.vld_o (dx_vld),
		.quo_o (qx),
		.side_o(dx_side)
	);

	cmu_div #(.NW(NW), .SIDE_W(DY_SW)) u_div_y (
		.clk   (clk),
		.arst_n(arst_n),
		.vld_i (vld_s3),
		.num_i (NW'(prod_y_s3)),
		.den_i (w_s3),
		.side_i({py_s3, ny_s3, sty}),
		.vld_o (dy_vld),
		.quo_o (qy),
		.side_o(dy_side)
	);

	logic o_straight;
	logic signed [31:0] o_px, o_nx, o_hn, o_nh, o_py, o_ny;
	logic signed [63:0] o_stx, o_sty, dx, dy;

	assign {o_straight, o_px, o_nx, o_hn, o_nh, o_stx} = dx_side;
	assign {o_py, o_ny, o_sty} = dy_side;
	assign dx = o_straight ? o_stx : 64'(qx);
	assign dy = o_straight ? o_sty : 64'(qy);

	// output stage: noise added last, saturate
	logic done_q;
	logic signed [31:0] new_x_q, new_y_q, new_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dx_vld && dy_vld;
		end
	end

	always_ff @(posedge clk) begin
		new_x_q <= sat32(64'(o_px) + dx + 64'(o_nx));
		new_y_q <= sat32(64'(o_py) + dy + 64'(o_ny));
		new_h_q <= sat32(64'(o_hn) + 64'(o_nh));
	end

	assign done        = done_q;
	assign new_x       = new_x_q;
	assign new_y       = new_y_q;
	assign new_heading = new_h_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##LAT done)
		else $error("transfer not completed after pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, LAT))
		else $error("result without matching input transfer");

	a_trig_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		t0_vld == t1_vld)
		else $error("trig units out of step");

	a_div_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		dx_vld == dy_vld)
		else $error("dividers out of step");

endmodule

// File: sim/ctrv_particle_motion_update_test.sv
module ctrv_particle_motion_update_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = cmu_pkg::FRAC_BITS_DEF;
	localparam int NITER = cmu_pkg::TRIG_ITER_DEF;
	localparam int LATENCY = 73 + NITER;

	typedef struct packed {
		logic signed [31:0] px, py, hd, spd, wr;
		logic [30:0] dt;
		logic signed [31:0] nx, ny, nh;
	} particle_t;

	typedef struct packed {
		logic signed [31:0] x, y, h;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic signed [31:0] pose_x = '0, pose_y = '0, heading = '0, speed = '0, turn_rate = '0;
	logic [30:0] time_step = '0;
	logic signed [31:0] noise_x = '0, noise_y = '0, noise_heading = '0;
	logic signed [31:0] new_x, new_y, new_heading;

	particle_t pending_q[$];
	pose_t moved_pose_q[$];
	int send_idle_pct = 12;
	bit hold_send = 1'b0;
	int mismatches = 0;
	bit stray = 1'b0;

	ctrv_particle_motion_update u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint sat_word(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unit_clamp(longint v);
		longint one = longint'(1) << FB;
		if (v > one) return one;
		if (v < -one) return -one;
		return v;
	endfunction

	// cordic sine/cosine with reduction to [-pi, pi) and fold to [-pi/2, pi/2]
	function automatic void sin_cos(input longint ang, output longint sn, output longint cs);
		longint r, num, k, z, x, y, nxv, xs, ys;
		bit flip;
		r = ang * (longint'(1) << (30 - FB));
		num = r + cmu_pkg::Q30_PI;
		if (num >= 0) k = num / cmu_pkg::Q30_TWO_PI;
		else k = -((-num + cmu_pkg::Q30_TWO_PI - 1) / cmu_pkg::Q30_TWO_PI);
		z = r - k * cmu_pkg::Q30_TWO_PI;
		flip = 1'b0;
		if (z > cmu_pkg::Q30_HALF_PI) begin
			z -= cmu_pkg::Q30_PI;
			flip = 1'b1;
		end else if (z < -cmu_pkg::Q30_HALF_PI) begin
			z += cmu_pkg::Q30_PI;
			flip = 1'b1;
		end
		x = 652032874;
		y = 0;
		for (int i = 0; i < NITER && i < 32; i++) begin
			ys = y >>> i;
			xs = x >>> i;
			if (z >= 0) begin
				nxv = x - ys;
				y = y + xs;
				z -= longint'(cmu_pkg::atan_q30(i));
			end else begin
				nxv = x + ys;
				y = y - xs;
				z += longint'(cmu_pkg::atan_q30(i));
			end
			x = nxv;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		cs = unit_clamp(x >>> (30 - FB));
		sn = unit_clamp(y >>> (30 - FB));
	endfunction

	function automatic pose_t move_particle(particle_t p);
		longint h, v, w, dt, aw, dx, dy, hn, s0, c0, s1, c1, d, phi;
		pose_t o;
		h = p.hd;
		v = p.spd;
		w = p.wr;
		dt = longint'({1'b0, p.dt});
		aw = w < 0 ? -w : w;
		sin_cos(h, s0, c0);
		if (aw * cmu_pkg::TURN_BOUND_INV < (longint'(1) << FB)) begin
			d = (v * dt) >>> FB;
			dx = (d * c0) >>> FB;
			dy = (d * s0) >>> FB;
			hn = h;
		end else begin
			phi = sat_word(h + ((w * dt) >>> FB));
			sin_cos(phi, s1, c1);
			dx = (v * (s1 - s0)) / w;
			dy = (v * (c0 - c1)) / w;
			hn = phi;
		end
		o.x = 32'(sat_word(longint'(p.px) + dx + longint'(p.nx)));
		o.y = 32'(sat_word(longint'(p.py) + dy + longint'(p.ny)));
		o.h = 32'(sat_word(hn + longint'(p.nh)));
		return o;
	endfunction

	// driver: present the next particle, possibly idle
	always @(negedge clk) begin
		if (arst_n && !(start && busy)) begin
			if (start) pending_q.pop_front();
			if (pending_q.size() > 0 && !hold_send &&
					$urandom_range(99) >= send_idle_pct) begin
				start <= 1'b1;
				pose_x <= pending_q[0].px;
				pose_y <= pending_q[0].py;
				heading <= pending_q[0].hd;
				speed <= pending_q[0].spd;
				turn_rate <= pending_q[0].wr;
				time_step <= pending_q[0].dt;
				noise_x <= pending_q[0].nx;
				noise_y <= pending_q[0].ny;
				noise_heading <= pending_q[0].nh;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		pose_t e;
		if (arst_n) begin
			if (start && !busy) begin
				e = move_particle({pose_x, pose_y, heading, speed, turn_rate, time_step,
					noise_x, noise_y, noise_heading});
				moved_pose_q.push_back(e);
			end
			if (done) begin
				if (moved_pose_q.size() == 0) begin
					stray = 1'b1;
					$display("unexpected result at %0t", $realtime);
				end else begin
					e = moved_pose_q.pop_front();
					if (new_x !== e.x || new_y !== e.y || new_heading !== e.h) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp x=%0d y=%0d h=%0d got x=%0d y=%0d h=%0d",
								e.x, e.y, e.h, new_x, new_y, new_heading);
					end
				end
			end
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($signed($urandom_range(200)) - 100);
			3, 4: return $urandom;
			default: return 32'($signed($urandom_range(2000000)) - 1000000);
		endcase
	endfunction

	function automatic particle_t rand_particle();
		particle_t p;
		p.px = rand_word();
		p.py = rand_word();
		p.hd = $urandom_range(3) == 0 ? rand_word() :
			32'($signed($urandom_range(900000)) - 450000);
		p.spd = rand_word();
		case ($urandom_range(4))
			0: p.wr = 32'($signed($urandom_range(12)) - 6);
			1: p.wr = rand_word();
			default: p.wr = 32'($signed($urandom_range(400000)) - 200000);
		endcase
		p.dt = $urandom_range(4) == 0 ? 31'($urandom) : 31'($urandom_range(200000));
		p.nx = $urandom_range(3) == 0 ? rand_word() : 32'($signed($urandom_range(2000)) - 1000);
		p.ny = $urandom_range(3) == 0 ? rand_word() : 32'($signed($urandom_range(2000)) - 1000);
		p.nh = $urandom_range(3) == 0 ? rand_word() : 32'($signed($urandom_range(2000)) - 1000);
		return p;
	endfunction

	task automatic drain();
		while (pending_q.size() > 0 || moved_pose_q.size() > 0) @(posedge clk);
	endtask

	initial begin
		particle_t p;
		// directed: straight path, turn bound edges, arcs, extremes
		p = '{32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 31'd65536, 32'sd0, 32'sd0, 32'sd0};
		pending_q.push_back(p);
		p.wr = 32'sd6; pending_q.push_back(p);       // just under bound
		p.wr = -32'sd6; pending_q.push_back(p);
		p.wr = 32'sd7; pending_q.push_back(p);       // just over bound
		p.wr = -32'sd7; pending_q.push_back(p);
		p.wr = 32'sd65536; p.hd = 32'sd102944; pending_q.push_back(p);
		p.hd = -32'sd205887; pending_q.push_back(p);
		p.hd = 32'h7fffffff; p.wr = 32'h7fffffff; p.dt = 31'h7fffffff; pending_q.push_back(p);
		p.hd = 32'h80000000; p.wr = 32'h80000000; pending_q.push_back(p);
		p = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'sd0, 31'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
		pending_q.push_back(p);
		p = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'sd0, 31'h7fffffff,
			32'h80000000, 32'h80000000, 32'h80000000};
		pending_q.push_back(p);
		p.wr = 32'h80000000; pending_q.push_back(p);
		p.spd = 32'h7fffffff; p.wr = 32'sd1; p.dt = 31'd0; pending_q.push_back(p);
		p = '{32'hffffffff, 32'hffffffff, 32'sd205887, 32'hffffffff, 32'hffffffff, 31'd1,
			32'hffffffff, 32'hffffffff, 32'hffffffff};
		pending_q.push_back(p);

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		drain();
		// hold off sending while the next twenty particles are queued
		hold_send = 1'b1;
		for (int i = 0; i < 20; i++) pending_q.push_back(rand_particle());
		repeat (5) @(posedge clk);
		hold_send = 1'b0;
		drain();
		send_idle_pct = 12;
		for (int i = 0; i < 400; i++) pending_q.push_back(rand_particle());
		drain();
		send_idle_pct = 49;
		for (int i = 0; i < 400; i++) pending_q.push_back(rand_particle());
		drain();
		send_idle_pct = 0;
		for (int i = 0; i < 420; i++) pending_q.push_back(rand_particle());
		drain();
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0 && !stray && moved_pose_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#200000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: ctrv_particle_motion_update.f
design/cmu_pkg.sv
design/cmu_rot_cell.sv
design/cmu_trig.sv
design/cmu_div_cell.sv
design/cmu_div.sv
design/ctrv_particle_motion_update.sv
sim/ctrv_particle_motion_update_test.sv
